@@ hdl/ssto_pkg.sv @@
// Package for the speed smoother with loss timeout and odometer.
// Holds register indexes, field widths, reset values and the rounding helper.
// Has no dependencies of its own.
package ssto_pkg;

   localparam int unsigned SpeedWidth  = 16;
   localparam int unsigned SmoothWidth = 24;
   localparam int unsigned WeightWidth = 9;
   localparam int unsigned DistWidth   = 48;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [WeightWidth-1:0] WeightOne       = 9'd256;
   localparam logic [WeightWidth-1:0] WeightReset     = 9'd77;
   localparam logic [SpeedWidth-1:0]  MinSpeedReset   = 16'd64;
   localparam logic [SpeedWidth-1:0]  LossTicksReset  = 16'd50;
   localparam logic [DistWidth-1:0]   DistMax         = {DistWidth{1'b1}};

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SMOOTHING_WEIGHT = 2'd0,
      CSR_MINIMUM_SPEED    = 2'd1,
      CSR_LOSS_TICKS       = 2'd2
   } csr_index_type;

   // Rounds a Q16.8 speed half up to whole 1/64 km/h units, saturating at 16 bits.
   function automatic logic [SpeedWidth-1:0] round_speed(input logic [SmoothWidth-1:0] q8);
      logic [SmoothWidth:0] sum;
      logic [SmoothWidth-8:0] whole;
      sum   = {1'b0, q8} + 25'd128;
      whole = sum[SmoothWidth:8];
      if (whole[SmoothWidth-8]) begin
         round_speed = {SpeedWidth{1'b1}};
      end else begin
         round_speed = whole[SpeedWidth-1:0];
      end
   endfunction

endpackage

@@ hdl/speed_smoother_timeout_odometer.sv @@
// Speed smoother with loss timeout and odometer, top level.
// Items go from the input register to the result register, which feeds the rsp_ channel.
// Throughput: one item per cycle unless rsp_ready stalls, set by the single update pass
// from the input register through the smoothing multipliers to the result register.
// Reset (synchronous, active high) restores the register defaults, clears the speed
// and distance, and loads the silence counter with the default loss limit.
// Depends on ssto_pkg.
module speed_smoother_timeout_odometer (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ssto_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [ssto_pkg::CsrDataWidth-1:0]    csr_wdata,
   // Input item channel, one item per 100 ms tick.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_fix_arrived,
   input  logic                                 req_fix_valid,
   input  logic [ssto_pkg::SpeedWidth-1:0]      req_fix_speed,
   // Result channel, one result per item.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_speed_report,
   output logic [ssto_pkg::SpeedWidth-1:0]      rsp_reported_speed,
   output logic                                 rsp_reported_valid,
   output logic [ssto_pkg::DistWidth-1:0]       rsp_distance_sum
);

   // Configuration registers.
   logic [ssto_pkg::WeightWidth-1:0] weight_ff;
   logic [ssto_pkg::SpeedWidth-1:0]  min_speed_ff;
   logic [ssto_pkg::SpeedWidth-1:0]  loss_ticks_ff;

   // Filter state.
   logic [ssto_pkg::SmoothWidth-1:0] smooth_ff, smooth_in;
   logic [ssto_pkg::SpeedWidth-1:0]  silence_ff, silence_in;
   logic [ssto_pkg::DistWidth-1:0]   dist_ff, dist_in;

   // Input register stage.
   logic                            in_valid_ff;
   logic                            in_arrived_ff;
   logic                            in_fix_valid_ff;
   logic [ssto_pkg::SpeedWidth-1:0] in_speed_ff;

   // Result register stage.
   logic                            out_valid_ff;
   logic                            out_report_ff, out_report_in;
   logic [ssto_pkg::SpeedWidth-1:0] out_speed_ff, out_speed_in;
   logic                            out_rvalid_ff, out_rvalid_in;

   logic advance;
   logic accept;

   // The input register moves its item into the result register whenever the
   // result register is empty or is being emptied in this cycle. The input side
   // is ready whenever the input register is empty or is moving on, so an item
   // can be taken every cycle as long as each finished result is taken at once.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Update datapath.
   logic [ssto_pkg::WeightWidth-1:0] alpha;
   logic [ssto_pkg::WeightWidth-1:0] alpha_rest;
   logic [32:0]                      old_term;
   logic [32:0]                      new_term;
   logic [33:0]                      ema_sum;
   logic [ssto_pkg::SmoothWidth-1:0] ema_q8;
   logic [ssto_pkg::SmoothWidth-1:0] floor_q8;
   logic [ssto_pkg::SmoothWidth-1:0] speed_fix;
   logic [ssto_pkg::SpeedWidth-1:0]  silence_fix;
   logic [ssto_pkg::SpeedWidth-1:0]  silence_next;
   logic                            counting;
   logic                            lost;
   logic [ssto_pkg::SpeedWidth-1:0]  fix_report_speed;
   logic [ssto_pkg::SpeedWidth-1:0]  dist_add;
   logic [ssto_pkg::DistWidth:0]     dist_sum;

   always_comb begin
      // A weight above one is treated as exactly one.
      alpha      = (weight_ff > ssto_pkg::WeightOne) ? ssto_pkg::WeightOne : weight_ff;
      alpha_rest = ssto_pkg::WeightOne - alpha;
      old_term   = 33'(smooth_ff) * 33'(alpha_rest);
      new_term   = 33'({in_speed_ff, 8'h00}) * 33'(alpha);
      ema_sum    = 34'(old_term) + 34'(new_term) + 34'd128;
      ema_q8     = ema_sum[31:8];
      floor_q8   = {min_speed_ff, 8'h00};

      // Stage one: the effect of an arriving fix.
      speed_fix   = smooth_ff;
      silence_fix = silence_ff;
      if (in_arrived_ff) begin
         silence_fix = '0;
         if (in_fix_valid_ff && (ema_q8 >= floor_q8)) begin
            speed_fix = ema_q8;
         end else begin
            speed_fix = '0;
         end
      end
      fix_report_speed = ssto_pkg::round_speed(speed_fix);

      // Stage two: the silence counter. It only runs below the limit, so the
      // increment reaches the limit exactly when loss is declared.
      counting     = silence_fix < loss_ticks_ff;
      silence_next = silence_fix + 16'd1;
      lost         = counting && (silence_next == loss_ticks_ff);
      silence_in   = counting ? silence_next : silence_fix;
      smooth_in    = lost ? '0 : speed_fix;

      // The loss report takes precedence over a fix report in the same tick.
      if (lost) begin
         out_report_in = 1'b1;
         out_speed_in  = '0;
         out_rvalid_in = 1'b0;
      end else if (in_arrived_ff) begin
         out_report_in = 1'b1;
         out_speed_in  = fix_report_speed;
         out_rvalid_in = in_fix_valid_ff;
      end else begin
         out_report_in = 1'b0;
         out_speed_in  = '0;
         out_rvalid_in = 1'b0;
      end

      // Odometer: add the rounded speed while moving above the floor,
      // saturating at the top of the sum.
      dist_add = ssto_pkg::round_speed(smooth_in);
      dist_sum = {1'b0, dist_ff} + 49'(dist_add);
      dist_in  = dist_ff;
      if (smooth_in > floor_q8) begin
         dist_in = dist_sum[ssto_pkg::DistWidth] ? ssto_pkg::DistMax
                                                 : dist_sum[ssto_pkg::DistWidth-1:0];
      end
   end

   // Control state, configuration and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff     <= ssto_pkg::WeightReset;
         min_speed_ff  <= ssto_pkg::MinSpeedReset;
         loss_ticks_ff <= ssto_pkg::LossTicksReset;
         smooth_ff     <= '0;
         silence_ff    <= ssto_pkg::LossTicksReset;
         dist_ff       <= '0;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ssto_pkg::CSR_SMOOTHING_WEIGHT: begin
                  weight_ff <= csr_wdata[ssto_pkg::WeightWidth-1:0];
               end
               ssto_pkg::CSR_MINIMUM_SPEED: begin
                  min_speed_ff <= csr_wdata;
               end
               ssto_pkg::CSR_LOSS_TICKS: begin
                  loss_ticks_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (advance) begin
            smooth_ff  <= smooth_in;
            silence_ff <= silence_in;
            dist_ff    <= dist_in;
         end
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_arrived_ff   <= req_fix_arrived;
         in_fix_valid_ff <= req_fix_valid;
         in_speed_ff     <= req_fix_speed;
      end
      if (advance) begin
         out_report_ff <= out_report_in;
         out_speed_ff  <= out_speed_in;
         out_rvalid_ff <= out_rvalid_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_speed_report   = out_report_ff;
   assign rsp_reported_speed = out_speed_ff;
   assign rsp_reported_valid = out_rvalid_ff;
   // The distance register only changes as an item moves into the result
   // register, so it always matches the result being shown.
   assign rsp_distance_sum   = dist_ff;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for speed_smoother_timeout_odometer.
// Depends on ssto_pkg and the top level; it predicts every result item in place.
module tb;

   // Cycle budget. The slowest correct run is about 1300 items, each with a
   // long sender gap and a long receiver stall.
   localparam int unsigned CycleLimit = 1000000;

   typedef struct packed {
      logic                           arrived;
      logic                           valid;
      logic [ssto_pkg::SpeedWidth-1:0] speed;
   } fix_tick_type;

   typedef struct packed {
      logic                           report;
      logic [ssto_pkg::SpeedWidth-1:0] speed;
      logic                           rep_valid;
      logic [ssto_pkg::DistWidth-1:0]  distance;
   } speed_result_type;

   // Clock, reset and every input of the block start at known values.
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   ssto_pkg::csr_index_type           csr_index = ssto_pkg::CSR_SMOOTHING_WEIGHT;
   logic [ssto_pkg::CsrDataWidth-1:0] csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_fix_arrived = 1'b0;
   logic                              req_fix_valid = 1'b0;
   logic [ssto_pkg::SpeedWidth-1:0]   req_fix_speed = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_speed_report;
   logic [ssto_pkg::SpeedWidth-1:0]   rsp_reported_speed;
   logic                              rsp_reported_valid;
   logic [ssto_pkg::DistWidth-1:0]    rsp_distance_sum;

   speed_smoother_timeout_odometer uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_fix_arrived    (req_fix_arrived),
      .req_fix_valid      (req_fix_valid),
      .req_fix_speed      (req_fix_speed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_speed_report   (rsp_speed_report),
      .rsp_reported_speed (rsp_reported_speed),
      .rsp_reported_valid (rsp_reported_valid),
      .rsp_distance_sum   (rsp_distance_sum)
   );

   always #2 clock = ~clock;

   // Ticks waiting to be driven, and the result items the block still owes.
   fix_tick_type     tick_queue[$];
   speed_result_type expected_reports[$];

   int unsigned   mismatches = 0;
   int unsigned   cycle_count = 0;
   int unsigned   req_gap = 0;
   int unsigned   rsp_stall = 0;
   // When set, the matching side never idles, which gives back-to-back stretches.
   logic          req_steady = 1'b0;
   logic          rsp_steady = 1'b0;

   // Shadow of the configuration registers, updated when a write is accepted.
   logic [ssto_pkg::WeightWidth-1:0] weight_cfg = ssto_pkg::WeightReset;
   logic [ssto_pkg::SpeedWidth-1:0]  min_speed_cfg = ssto_pkg::MinSpeedReset;
   logic [ssto_pkg::SpeedWidth-1:0]  loss_cfg = ssto_pkg::LossTicksReset;

   // Shadow of the block's state. The silence counter starts at the reset loss
   // limit, so no loss is declared before the first fix.
   logic [ssto_pkg::SmoothWidth-1:0] smoothed = '0;
   logic [ssto_pkg::SpeedWidth-1:0]  silence_count = ssto_pkg::LossTicksReset;
   logic [ssto_pkg::DistWidth-1:0]   distance_total = '0;

   // Converts a speed with 8 fraction bits to whole units, rounding half up.
   function automatic logic [ssto_pkg::SpeedWidth-1:0] whole_speed(
         input logic [ssto_pkg::SmoothWidth-1:0] q8);
      logic [ssto_pkg::SmoothWidth-1:0] biased;
      if (q8 >= 24'hFFFF80) begin
         return {ssto_pkg::SpeedWidth{1'b1}};
      end
      biased = q8 + 24'd128;
      return biased[ssto_pkg::SmoothWidth-1:8];
   endfunction

   // Advances the shadow state by one tick and returns the result item it causes.
   function automatic speed_result_type smooth_and_measure(input logic arrived,
         input logic valid, input logic [ssto_pkg::SpeedWidth-1:0] fix);
      speed_result_type                 r;
      logic [39:0]                      alpha;
      logic [39:0]                      old_part;
      logic [39:0]                      new_part;
      logic [39:0]                      blend;
      logic [ssto_pkg::SmoothWidth-1:0] floor_q8;
      logic [ssto_pkg::DistWidth-1:0]   step;
      r = '0;
      floor_q8 = {min_speed_cfg, 8'h00};
      if (arrived) begin
         silence_count = '0;
         if (valid) begin
            // A weight above one is treated as exactly one.
            alpha = 40'((weight_cfg > ssto_pkg::WeightOne) ? ssto_pkg::WeightOne
                                                             : weight_cfg);
            old_part = 40'(smoothed);
            new_part = 40'({fix, 8'h00});
            blend = old_part * (40'd256 - alpha) + new_part * alpha + 40'd128;
            smoothed = blend[31:8];
            if (smoothed < floor_q8) begin
               smoothed = '0;
            end
         end else begin
            smoothed = '0;
         end
         r.report = 1'b1;
         r.speed = whole_speed(smoothed);
         r.rep_valid = valid;
      end
      // The counter only runs while below the limit; a lowered limit freezes it.
      if (silence_count < loss_cfg) begin
         silence_count = silence_count + 16'd1;
         if (silence_count >= loss_cfg) begin
            r.report = 1'b1;
            r.speed = '0;
            r.rep_valid = 1'b0;
            smoothed = '0;
         end
      end
      if (smoothed > floor_q8) begin
         step = {32'd0, whole_speed(smoothed)};
         if (distance_total > ssto_pkg::DistMax - step) begin
            distance_total = ssto_pkg::DistMax;
         end else begin
            distance_total = distance_total + step;
         end
      end
      r.distance = distance_total;
      return r;
   endfunction

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(3, 1);
      end else if (r < 96) begin
         return $urandom_range(12, 4);
      end
      return $urandom_range(80, 20);
   endfunction

   // Fix speeds cluster around the current floor so the compare is hit often.
   function automatic logic [ssto_pkg::SpeedWidth-1:0] pick_speed();
      int unsigned r;
      int unsigned lo;
      int unsigned hi;
      r = $urandom_range(9);
      lo = (min_speed_cfg > 200) ? min_speed_cfg - 200 : 0;
      hi = (min_speed_cfg < 65335) ? min_speed_cfg + 200 : 65535;
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return {ssto_pkg::SpeedWidth{1'b1}};
      end else if (r < 6) begin
         return 16'($urandom_range(65535));
      end
      return 16'($urandom_range(hi, lo));
   endfunction

   // Driver: presents the next queued tick once the current one is taken.
   // The prediction is made at the edge where the item is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_reports.push_back(smooth_and_measure(req_fix_arrived, req_fix_valid,
                                                          req_fix_speed));
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
               fix_tick_type next_tick;
               next_tick = tick_queue.pop_front();
               req_fix_arrived <= next_tick.arrived;
               req_fix_valid <= next_tick.valid;
               req_fix_speed <= next_tick.speed;
               req_valid <= 1'b1;
               req_gap = req_steady ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result item against the oldest prediction
   // and throttles the result channel with random stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $error("result item with no prediction waiting");
            mismatches = mismatches + 1;
         end else begin
            speed_result_type want;
            want = expected_reports.pop_front();
            if (rsp_speed_report !== want.report) begin
               $error("speed_report: expected %0d, got %0d", want.report, rsp_speed_report);
               mismatches = mismatches + 1;
            end
            if (rsp_reported_speed !== want.speed) begin
               $error("reported_speed: expected %0d, got %0d", want.speed,
                      rsp_reported_speed);
               mismatches = mismatches + 1;
            end
            if (rsp_reported_valid !== want.rep_valid) begin
               $error("reported_valid: expected %0d, got %0d", want.rep_valid,
                      rsp_reported_valid);
               mismatches = mismatches + 1;
            end
            if (rsp_distance_sum !== want.distance) begin
               $error("distance_sum: expected %0d, got %0d", want.distance, rsp_distance_sum);
               mismatches = mismatches + 1;
            end
         end
      end
      if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = rsp_steady ? 0 : pick_gap();
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic add_tick(input logic arrived, input logic valid,
                           input logic [ssto_pkg::SpeedWidth-1:0] speed);
      fix_tick_type t;
      t.arrived = arrived;
      t.valid = valid;
      t.speed = speed;
      tick_queue.push_back(t);
   endtask

   // Holds the sender until every queued tick is taken and every result item
   // has come back, then lets the pipeline settle.
   task automatic drain();
      do begin
         @(posedge clock);
      end while (tick_queue.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // One register write; valid stays high so back-to-back writes need no gap.
   task automatic write_csr(input ssto_pkg::csr_index_type idx,
                            input logic [ssto_pkg::CsrDataWidth-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!(csr_valid && csr_ready));
      case (idx)
         ssto_pkg::CSR_SMOOTHING_WEIGHT: weight_cfg = data[ssto_pkg::WeightWidth-1:0];
         ssto_pkg::CSR_MINIMUM_SPEED:    min_speed_cfg = data;
         ssto_pkg::CSR_LOSS_TICKS:       loss_cfg = data;
         default: ;
      endcase
   endtask

   // Only called with the block idle, right after a drain.
   task automatic set_config(input logic [ssto_pkg::CsrDataWidth-1:0] weight,
                             input logic [ssto_pkg::CsrDataWidth-1:0] min_speed,
                             input logic [ssto_pkg::CsrDataWidth-1:0] loss);
      write_csr(ssto_pkg::CSR_SMOOTHING_WEIGHT, weight);
      write_csr(ssto_pkg::CSR_MINIMUM_SPEED, min_speed);
      write_csr(ssto_pkg::CSR_LOSS_TICKS, loss);
      csr_valid <= 1'b0;
   endtask

   // A random phase: fixes arrive at the given rate, mostly valid with random
   // speeds, and some invalid ones come as noise. Halfway through the
   // sender waits for every result item before going on.
   task automatic random_phase(input logic [ssto_pkg::CsrDataWidth-1:0] weight,
                               input logic [ssto_pkg::CsrDataWidth-1:0] min_speed,
                               input logic [ssto_pkg::CsrDataWidth-1:0] loss,
                               input int unsigned arrive_pct, input int unsigned count);
      int unsigned k;
      set_config(weight, min_speed, loss);
      req_steady = ($urandom_range(3) == 0);
      rsp_steady = ($urandom_range(3) == 0);
      for (k = 0; k < count; k++) begin
         if (k == count / 2) begin
            drain();
         end
         add_tick($urandom_range(99) < arrive_pct, $urandom_range(99) < 88, pick_speed());
      end
      drain();
   endtask

   initial begin
      int unsigned k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: silent ticks with junk fields, full speed, an invalid
      // fix that carries a speed to be ignored, zero speed, and a fix whose
      // average stays under the floor and is forced to zero.
      add_tick(1'b0, 1'b0, 16'h0000);
      add_tick(1'b0, 1'b1, 16'hFFFF);
      repeat (3) add_tick(1'b1, 1'b1, 16'hFFFF);
      add_tick(1'b1, 1'b0, 16'hFFFF);
      add_tick(1'b1, 1'b1, 16'h0000);
      add_tick(1'b1, 1'b1, 16'd64);
      repeat (2) add_tick(1'b1, 1'b1, 16'd40000);
      repeat (3) add_tick(1'b0, 1'b0, 16'h0000);
      drain();

      // A weight written with every bit set saturates to one, and a loss limit
      // of one makes the fix and the loss land on the same tick.
      set_config(16'hFFFF, 16'd0, 16'd1);
      add_tick(1'b1, 1'b1, 16'd12345);
      add_tick(1'b0, 1'b0, 16'h0000);
      add_tick(1'b1, 1'b1, 16'hFFFF);
      drain();

      // Weight of exactly one, highest floor, and a zero limit that never
      // declares loss. A speed equal to the floor survives but adds no distance.
      set_config(16'd256, 16'hFFFF, 16'd0);
      add_tick(1'b1, 1'b1, 16'hFFFF);
      add_tick(1'b0, 1'b0, 16'h0000);
      add_tick(1'b1, 1'b1, 16'hFFFE);
      drain();

      // Zero weight keeps the old speed whatever arrives.
      set_config(16'd0, 16'd100, 16'd50);
      add_tick(1'b1, 1'b1, 16'd5000);
      drain();

      // Let the silence counter climb, then lower the limit below it: the
      // counter holds until the next fix restarts it, and then loss follows.
      set_config(16'd200, 16'd0, 16'd50);
      add_tick(1'b1, 1'b1, 16'd3000);
      for (k = 0; k < 4; k++) add_tick(1'b0, 1'b0, 16'h0000);
      drain();
      set_config(16'd200, 16'd0, 16'd3);
      add_tick(1'b0, 1'b0, 16'h0000);
      add_tick(1'b1, 1'b1, 16'd3000);
      repeat (3) add_tick(1'b0, 1'b0, 16'h0000);
      drain();

      // Random part, about 1200 items over a range of settings.
      random_phase(16'd77, 16'd64, 16'd50, 90, 150);
      random_phase(16'd256, 16'd0, 16'd3, 60, 150);
      random_phase(16'd1, 16'hFFFF, 16'd7, 70, 150);
      random_phase(16'hFFFF, 16'd300, 16'd2, 40, 150);
      random_phase(16'd0, 16'd0, 16'hFFFF, 80, 150);
      random_phase(16'd128, 16'd1000, 16'd1, 50, 150);
      random_phase(16'($urandom_range(300)), 16'($urandom_range(4000)),
                   16'($urandom_range(20, 2)), 60, 150);
      random_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(10, 1)), 35, 150);

      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/ssto_pkg.sv
hdl/speed_smoother_timeout_odometer.sv
dv/tb.sv
